### src/epc_pkg.sv
// epc_pkg: shared types and constants for the encoder position and edge
// capture unit. No dependencies; imported by the top level and epc_debounce.
package epc_pkg;

  // Default table depth (entries per edge table)
  localparam int EPC_DEPTH_DEFAULT = 128;

  // Field widths fixed by the interface
  localparam int POS_W   = 32;
  localparam int CNT_W   = 8;
  localparam int SLOT_W  = 7;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 2;

  // Filter counter saturation value
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration register reset values
  localparam logic [7:0] STEP_RESET     = 8'd2;
  localparam logic       DIR_POS_RESET  = 1'b1;
  localparam logic [7:0] DEBOUNCE_RESET = 8'd1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SIZE     = 2'd0,
    CFG_DIRECTION_POS = 2'd1,
    CFG_DEBOUNCE      = 2'd2
  } epc_cfg_idx_t;

  // Operation codes
  typedef enum logic [1:0] {
    OP_ENCODER = 2'd0,
    OP_TICK    = 2'd1,
    OP_SET_POS = 2'd2,
    OP_READ    = 2'd3
  } epc_op_t;

  // Control sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } epc_state_t;

  // Edge capture report from the debounce filter
  typedef struct packed {
    logic captured;
    logic rising;
  } epc_edge_t;

endpackage

### src/encoder_position_edge_capture_unit.sv
// Encoder position and edge capture unit: top level with control sequencer,
// position register, rise and fall edge tables and the result register.
// Depends on epc_pkg, epc_ram and epc_debounce.
//
// Keeps a wrapping signed 32-bit position, moved by encoder overflow events
// and loaded by set-position transactions; sample ticks debounce the
// active-low sensor pin and each debounced edge stores the position in the
// rise or fall table at a write index that sticks at DEPTH-1. Every input
// transaction yields one result transaction. Encoder, tick and set-position
// results load the result register directly; a table read first passes the
// registered RAM read port and the read state. A new transaction is taken
// once the sequencer is idle and the result register is empty or being
// emptied, so the rate is one transaction per cycle while results are taken
// and no read is in its read state. The tables need no clearing after reset;
// an unwritten slot reads undefined. Reads at DEPTH or above return 0.
module encoder_position_edge_capture_unit import epc_pkg::*; #(
  parameter int DEPTH = EPC_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  // input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               operation,
  input  logic                     count_down,
  input  logic                     running,
  input  logic                     pin_level,
  input  logic signed [POS_W-1:0]  new_position,
  input  logic                     table_select,
  input  logic [SLOT_W-1:0]        entry_index,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [POS_W-1:0]  position,
  output logic                     edge_captured,
  output logic                     edge_rising,
  output logic [SLOT_W-1:0]        edge_slot,
  output logic                     sensor_state,
  output logic [SLOT_W-1:0]        rise_count,
  output logic [SLOT_W-1:0]        fall_count,
  output logic signed [POS_W-1:0]  entry_value
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = ((IW > SLOT_W) ? IW : SLOT_W) + 1;

  // Configuration registers
  logic [7:0] step_size;
  logic       direction_positive;
  logic [7:0] debounce_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size          <= STEP_RESET;
      direction_positive <= DIR_POS_RESET;
      debounce_limit     <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_SIZE:     step_size          <= cfg_data;
        CFG_DIRECTION_POS: direction_positive <= cfg_data[0];
        CFG_DEBOUNCE:      debounce_limit     <= cfg_data;
        default:           ;
      endcase
    end
  end

  // Handshake and decode
  epc_state_t state, state_next;
  epc_op_t    op;
  logic       accept;
  logic       do_tick;
  logic       do_read;

  assign op       = epc_op_t'(operation);
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign do_tick  = accept && (op == OP_TICK) && running;
  assign do_read  = accept && (op == OP_READ);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (do_read) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Position accumulator
  logic [POS_W-1:0] position_acc, position_next;
  logic             subtract;

  assign subtract = (count_down == direction_positive);

  always_comb begin
    position_next = position_acc;
    if (accept) begin
      case (op)
        OP_ENCODER: position_next = subtract ? position_acc - POS_W'(step_size)
                                             : position_acc + POS_W'(step_size);
        OP_SET_POS: position_next = POS_W'(new_position);
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_acc <= '0;
    end else begin
      position_acc <= position_next;
    end
  end

  // Debounce filter and edge indexes
  epc_edge_t     edge_info;
  logic [IW-1:0] slot;
  logic          sensor_after;
  logic [IW-1:0] rise_after;
  logic [IW-1:0] fall_after;

  epc_debounce #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_debounce (
    .clk            (clk),
    .rst            (rst),
    .tick           (do_tick),
    .pin_level      (pin_level),
    .debounce_limit (debounce_limit),
    .edge_info      (edge_info),
    .edge_slot      (slot),
    .sensor_after   (sensor_after),
    .rise_after     (rise_after),
    .fall_after     (fall_after)
  );

  // Edge tables
  logic [IW-1:0]    raddr;
  logic [CW-1:0]    idx_ext;
  logic             in_range;
  logic [POS_W-1:0] rise_rdata, fall_rdata;
  logic             rd_sel;
  logic             rd_in_range;

  assign raddr    = IW'(entry_index);
  assign idx_ext  = CW'(entry_index);
  assign in_range = idx_ext < CW'(DEPTH);

  epc_ram #(
    .DEPTH (DEPTH),
    .AW    (IW),
    .DW    (POS_W)
  ) u_rise_table (
    .clk   (clk),
    .we    (edge_info.captured && edge_info.rising),
    .waddr (slot),
    .wdata (position_acc),
    .re    (do_read),
    .raddr (raddr),
    .rdata (rise_rdata)
  );

  epc_ram #(
    .DEPTH (DEPTH),
    .AW    (IW),
    .DW    (POS_W)
  ) u_fall_table (
    .clk   (clk),
    .we    (edge_info.captured && !edge_info.rising),
    .waddr (slot),
    .wdata (position_acc),
    .re    (do_read),
    .raddr (raddr),
    .rdata (fall_rdata)
  );

  // Read transaction context
  always_ff @(posedge clk) begin
    if (do_read) begin
      rd_sel      <= table_select;
      rd_in_range <= in_range;
    end
  end

  // Result register
  logic load_now;
  logic load_read;

  assign load_now  = accept && (op != OP_READ);
  assign load_read = (state == ST_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_now || load_read) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_now || load_read) begin
      position      <= position_next;
      edge_captured <= edge_info.captured;
      edge_rising   <= edge_info.rising;
      edge_slot     <= SLOT_W'(slot);
      sensor_state  <= sensor_after;
      rise_count    <= SLOT_W'(rise_after);
      fall_count    <= SLOT_W'(fall_after);
      if (load_read && rd_in_range) begin
        entry_value <= rd_sel ? fall_rdata : rise_rdata;
      end else begin
        entry_value <= '0;
      end
    end
  end

endmodule

### src/epc_ram.sv
// epc_ram: single-write, single-read synchronous RAM holding one edge table.
// Read data is registered. Uses no package items.
module epc_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/epc_debounce.sv
// epc_debounce: sensor debounce filter with saturating counters, edge
// detection and saturating table write indexes. Depends on epc_pkg.
module epc_debounce import epc_pkg::*; #(
  parameter int DEPTH = EPC_DEPTH_DEFAULT,
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             tick,
  input  logic             pin_level,
  input  logic [CNT_W-1:0] debounce_limit,
  output epc_edge_t        edge_info,
  output logic [IW-1:0]    edge_slot,
  output logic             sensor_after,
  output logic [IW-1:0]    rise_after,
  output logic [IW-1:0]    fall_after
);

  localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

  logic [CNT_W-1:0] high_cnt, high_cnt_next;
  logic [CNT_W-1:0] low_cnt, low_cnt_next;
  logic             sensor_flag, sensor_flag_next;
  logic             sensor_prev, sensor_prev_next;
  logic [IW-1:0]    rise_index, rise_index_next;
  logic [IW-1:0]    fall_index, fall_index_next;

  // Filter and edge detection for one tick
  always_comb begin
    high_cnt_next    = high_cnt;
    low_cnt_next     = low_cnt;
    sensor_flag_next = sensor_flag;
    sensor_prev_next = sensor_prev;
    rise_index_next  = rise_index;
    fall_index_next  = fall_index;
    edge_info        = '0;
    edge_slot        = '0;
    if (tick) begin
      if (pin_level) begin
        high_cnt_next = (high_cnt == CNT_MAX) ? CNT_MAX : high_cnt + 1'b1;
        if (high_cnt_next > debounce_limit) begin
          sensor_flag_next = 1'b0;
          low_cnt_next     = '0;
        end
      end else begin
        low_cnt_next = (low_cnt == CNT_MAX) ? CNT_MAX : low_cnt + 1'b1;
        if (low_cnt_next > debounce_limit) begin
          sensor_flag_next = 1'b1;
          high_cnt_next    = '0;
        end
      end
      if (sensor_flag_next != sensor_prev) begin
        sensor_prev_next   = sensor_flag_next;
        edge_info.captured = 1'b1;
        edge_info.rising   = sensor_flag_next;
        if (sensor_flag_next) begin
          edge_slot       = rise_index;
          rise_index_next = (rise_index == LAST_SLOT) ? LAST_SLOT : rise_index + 1'b1;
        end else begin
          edge_slot       = fall_index;
          fall_index_next = (fall_index == LAST_SLOT) ? LAST_SLOT : fall_index + 1'b1;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      high_cnt    <= '0;
      low_cnt     <= '0;
      sensor_flag <= 1'b0;
      sensor_prev <= 1'b0;
      rise_index  <= '0;
      fall_index  <= '0;
    end else begin
      high_cnt    <= high_cnt_next;
      low_cnt     <= low_cnt_next;
      sensor_flag <= sensor_flag_next;
      sensor_prev <= sensor_prev_next;
      rise_index  <= rise_index_next;
      fall_index  <= fall_index_next;
    end
  end

  assign sensor_after = sensor_flag_next;
  assign rise_after   = rise_index_next;
  assign fall_after   = fall_index_next;

endmodule

### test/tb_encoder_position_edge_capture_unit.sv
// Self-checking testbench for encoder_position_edge_capture_unit: random and
// directed transactions checked against an in-bench model of the unit.
// Depends on epc_pkg and the unit under src.
module tb_encoder_position_edge_capture_unit;
  import epc_pkg::*;

  localparam int TBL_DEPTH      = EPC_DEPTH_DEFAULT;
  localparam int RESET_CYCLES   = 9;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 80;
  localparam int MAX_REPORTED   = 10;

  // One input transaction and one result transaction
  typedef struct packed {
    epc_op_t                op;
    logic                   count_down;
    logic                   running;
    logic                   pin_level;
    logic signed [POS_W-1:0] new_position;
    logic                   table_select;
    logic [SLOT_W-1:0]      entry_index;
  } cmd_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                   edge_captured;
    logic                   edge_rising;
    logic [SLOT_W-1:0]      edge_slot;
    logic                   sensor_state;
    logic [SLOT_W-1:0]      rise_count;
    logic [SLOT_W-1:0]      fall_count;
    logic signed [POS_W-1:0] entry_value;
  } report_t;

  // DUT signals
  logic                    clk;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              operation = '0;
  logic                    count_down = 1'b0;
  logic                    running = 1'b0;
  logic                    pin_level = 1'b0;
  logic signed [POS_W-1:0] new_position = '0;
  logic                    table_select = 1'b0;
  logic [SLOT_W-1:0]       entry_index = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [POS_W-1:0] position;
  logic                    edge_captured;
  logic                    edge_rising;
  logic [SLOT_W-1:0]       edge_slot;
  logic                    sensor_state;
  logic [SLOT_W-1:0]       rise_count;
  logic [SLOT_W-1:0]       fall_count;
  logic signed [POS_W-1:0] entry_value;

  encoder_position_edge_capture_unit #(.DEPTH(TBL_DEPTH)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .count_down(count_down), .running(running),
    .pin_level(pin_level), .new_position(new_position),
    .table_select(table_select), .entry_index(entry_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .position(position), .edge_captured(edge_captured), .edge_rising(edge_rising),
    .edge_slot(edge_slot), .sensor_state(sensor_state), .rise_count(rise_count),
    .fall_count(fall_count), .entry_value(entry_value)
  );

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Queues and bookkeeping
  cmd_t    queued_ops[$];
  report_t due_reports[$];
  cmd_t    cmd_on_bus;
  report_t got_report;
  report_t want_report;
  string   diff_fields;
  logic    in_taken = 1'b0;
  logic    out_taken = 1'b0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_left = 0;
  int      stall_cycles = 0;
  int      error_count = 0;
  int      cmds_taken = 0;
  int      reads_taken = 0;
  int      reports_seen = 0;
  int      rises_seen = 0;
  int      falls_seen = 0;
  int      reg_writes = 0;

  // Model of the unit: configuration and state
  logic [7:0]       step_cfg = STEP_RESET;
  logic             dir_cfg = DIR_POS_RESET;
  logic [7:0]       debounce_cfg = DEBOUNCE_RESET;
  logic [POS_W-1:0] pos_acc = '0;
  logic [CNT_W-1:0] hi_cnt = '0;
  logic [CNT_W-1:0] lo_cnt = '0;
  logic             flag = 1'b0;
  logic             flag_prev = 1'b0;
  logic [SLOT_W-1:0] rise_idx = '0;
  logic [SLOT_W-1:0] fall_idx = '0;
  logic [POS_W-1:0] rise_mem [TBL_DEPTH];
  logic [POS_W-1:0] fall_mem [TBL_DEPTH];
  int               rise_fill = 0;   // slots 0..fill-1 hold a position
  int               fall_fill = 0;

  // Advance the model by one transaction and return the result it gives
  function automatic report_t capture_outcome(cmd_t c);
    report_t r;
    r = '0;
    case (c.op)
      OP_ENCODER: begin
        // step is subtracted when the direction flag matches the polarity
        if (c.count_down == dir_cfg) pos_acc = pos_acc - step_cfg;
        else pos_acc = pos_acc + step_cfg;
      end
      OP_TICK: begin
        if (c.running) begin
          if (c.pin_level) begin
            if (hi_cnt != CNT_MAX) hi_cnt = hi_cnt + 1'b1;
            if (hi_cnt > debounce_cfg) begin
              flag = 1'b0;
              lo_cnt = '0;
            end
          end else begin
            if (lo_cnt != CNT_MAX) lo_cnt = lo_cnt + 1'b1;
            if (lo_cnt > debounce_cfg) begin
              flag = 1'b1;
              hi_cnt = '0;
            end
          end
          if (flag != flag_prev) begin
            flag_prev = flag;
            r.edge_captured = 1'b1;
            if (flag) begin
              r.edge_rising = 1'b1;
              r.edge_slot = rise_idx;
              rise_mem[rise_idx] = pos_acc;
              if (int'(rise_idx) + 1 > rise_fill) rise_fill = int'(rise_idx) + 1;
              if (rise_idx != SLOT_W'(TBL_DEPTH - 1)) rise_idx = rise_idx + 1'b1;
            end else begin
              r.edge_slot = fall_idx;
              fall_mem[fall_idx] = pos_acc;
              if (int'(fall_idx) + 1 > fall_fill) fall_fill = int'(fall_idx) + 1;
              if (fall_idx != SLOT_W'(TBL_DEPTH - 1)) fall_idx = fall_idx + 1'b1;
            end
          end
        end
      end
      OP_SET_POS: pos_acc = c.new_position;
      default: begin
        if (int'(c.entry_index) < TBL_DEPTH)
          r.entry_value = c.table_select ? fall_mem[c.entry_index] : rise_mem[c.entry_index];
      end
    endcase
    r.position = pos_acc;
    r.sensor_state = flag;
    r.rise_count = rise_idx;
    r.fall_count = fall_idx;
    return r;
  endfunction

  // Point a read at a slot that already holds a position; with both tables
  // still empty the transaction becomes an encoder event
  function automatic cmd_t aim_read(cmd_t c);
    int fill;
    if (c.op == OP_READ) begin
      fill = c.table_select ? fall_fill : rise_fill;
      if (fill == 0) begin
        c.table_select = ~c.table_select;
        fill = c.table_select ? fall_fill : rise_fill;
      end
      if (fill == 0) c.op = OP_ENCODER;
      else c.entry_index = SLOT_W'($urandom_range(0, fill - 1));
    end
    return c;
  endfunction

  function automatic string field_diffs(report_t e, report_t g);
    string s;
    s = "";
    if (e.position !== g.position) s = {s, " position"};
    if (e.edge_captured !== g.edge_captured) s = {s, " edge_captured"};
    if (e.edge_rising !== g.edge_rising) s = {s, " edge_rising"};
    if (e.edge_slot !== g.edge_slot) s = {s, " edge_slot"};
    if (e.sensor_state !== g.sensor_state) s = {s, " sensor_state"};
    if (e.rise_count !== g.rise_count) s = {s, " rise_count"};
    if (e.fall_count !== g.fall_count) s = {s, " fall_count"};
    if (e.entry_value !== g.entry_value) s = {s, " entry_value"};
    return s;
  endfunction

  function automatic string show_report(report_t r);
    return $sformatf("pos=%0d cap=%b rise=%b slot=%0d sensor=%b rc=%0d fc=%0d entry=%0d",
                     r.position, r.edge_captured, r.edge_rising, r.edge_slot,
                     r.sensor_state, r.rise_count, r.fall_count, r.entry_value);
  endfunction

  // Handshake snapshot, taken between edges so the posedge logic is race free
  always @(negedge clk) begin
    in_taken = in_valid && in_ready;
    out_taken = out_valid && out_ready;
    got_report = '{position, edge_captured, edge_rising, edge_slot, sensor_state,
                   rise_count, fall_count, entry_value};
  end

  // Driver: model on acceptance, then offer the next queued transaction
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_taken) begin
        due_reports.push_back(capture_outcome(cmd_on_bus));
        cmds_taken++;
        if (cmd_on_bus.op == OP_READ) reads_taken++;
      end
      if (!in_valid || in_taken) begin
        if (queued_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cmd_on_bus = aim_read(queued_ops.pop_front());
          in_valid <= 1'b1;
          operation <= cmd_on_bus.op;
          count_down <= cmd_on_bus.count_down;
          running <= cmd_on_bus.running;
          pin_level <= cmd_on_bus.pin_level;
          new_position <= cmd_on_bus.new_position;
          table_select <= cmd_on_bus.table_select;
          entry_index <= cmd_on_bus.entry_index;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_taken) begin
        reports_seen++;
        if (due_reports.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTED)
            $display("unexpected result transaction: %s", show_report(got_report));
        end else begin
          want_report = due_reports.pop_front();
          diff_fields = field_diffs(want_report, got_report);
          if (diff_fields != "") begin
            error_count++;
            if (error_count <= MAX_REPORTED) begin
              $display("result %0d mismatch in:%s", reports_seen, diff_fields);
              $display("  expected %s", show_report(want_report));
              $display("  actual   %s", show_report(got_report));
            end
          end
          if (want_report.edge_captured) begin
            if (want_report.edge_rising) rises_seen++;
            else falls_seen++;
          end
        end
        // long hold-offs so the unit backs up and stalls its input
        if (reports_seen == 250 || reports_seen == 1450) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || in_taken || out_taken || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic cmd_t make_cmd(epc_op_t op, logic dn, logic run, logic pin,
                                    logic [POS_W-1:0] np, logic sel,
                                    logic [SLOT_W-1:0] idx);
    cmd_t c;
    c.op = op;
    c.count_down = dn;
    c.running = run;
    c.pin_level = pin;
    c.new_position = np;
    c.table_select = sel;
    c.entry_index = idx;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    return make_cmd(epc_op_t'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                    1'($urandom_range(0, 1)), SLOT_W'($urandom_range(0, 127)));
  endfunction

  // Wait until the unit is idle with nothing outstanding
  task automatic wait_drained();
    do @(negedge clk);
    while (queued_ops.size() != 0 || in_valid || due_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(epc_cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_STEP_SIZE:     step_cfg = val;
      CFG_DIRECTION_POS: dir_cfg = val[0];
      default:           debounce_cfg = val;
    endcase
  endtask

  task automatic program_setup(logic [7:0] step, logic dir, logic [7:0] deb);
    write_reg(CFG_STEP_SIZE, step);
    write_reg(CFG_DIRECTION_POS, CFG_W'(dir));
    write_reg(CFG_DEBOUNCE, deb);
  endtask

  // Random part: mostly debounce runs long enough to flip the sensor, with
  // other operations mixed in, plus cut-short runs and bursts of noise
  task automatic gen_phase(int budget);
    int   made;
    int   run_len;
    logic run_pin;
    cmd_t c;
    made = 0;
    run_pin = 1'b0;
    while (made < budget) begin
      if ($urandom_range(0, 99) < 70) begin
        if ($urandom_range(0, 4) != 0) run_pin = ~run_pin;
        run_len = int'(debounce_cfg) + 1 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
        if (debounce_cfg != 0 && $urandom_range(0, 6) == 0)
          run_len = $urandom_range(1, debounce_cfg);
        while (run_len > 0) begin
          c = random_cmd();
          if ($urandom_range(0, 3) == 0) begin
            if (c.op == OP_TICK) c.op = OP_ENCODER;
            made++;
          end else begin
            c.op = OP_TICK;
            c.pin_level = run_pin;
            c.running = ($urandom_range(0, 19) != 0);
            if (c.running) begin
              run_len--;
              made++;
            end
          end
          queued_ops.push_back(c);
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          c = random_cmd();
          queued_ops.push_back(c);
          if (!(c.op == OP_TICK && !c.running)) made++;
        end
      end
    end
  endtask

  // Stimulus sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed part under reset settings: wrap, stopped tick, both edges
    send_idle_pct = 14;
    recv_idle_pct = 58;
    queued_ops.push_back(make_cmd(OP_ENCODER, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 7'h00));
    queued_ops.push_back(make_cmd(OP_ENCODER, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 7'h7F));
    queued_ops.push_back(make_cmd(OP_SET_POS, 1'b0, 1'b0, 1'b0, 32'h7FFF_FFFF, 1'b0, 7'h00));
    queued_ops.push_back(make_cmd(OP_ENCODER, 1'b0, 1'b1, 1'b0, 32'h0, 1'b1, 7'h55));
    queued_ops.push_back(make_cmd(OP_SET_POS, 1'b1, 1'b1, 1'b1, 32'h8000_0000, 1'b1, 7'h2A));
    queued_ops.push_back(make_cmd(OP_ENCODER, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 7'h00));
    queued_ops.push_back(make_cmd(OP_TICK, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 7'h00));
    queued_ops.push_back(make_cmd(OP_TICK, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0, 7'h00));
    queued_ops.push_back(make_cmd(OP_TICK, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0, 7'h00));
    queued_ops.push_back(make_cmd(OP_READ, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 7'h00));
    queued_ops.push_back(make_cmd(OP_ENCODER, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 7'h00));
    queued_ops.push_back(make_cmd(OP_TICK, 1'b1, 1'b1, 1'b1, 32'h0, 1'b1, 7'h00));
    queued_ops.push_back(make_cmd(OP_TICK, 1'b1, 1'b1, 1'b1, 32'h0, 1'b1, 7'h00));
    queued_ops.push_back(make_cmd(OP_READ, 1'b0, 1'b0, 1'b0, 32'h0, 1'b1, 7'h00));
    queued_ops.push_back(make_cmd(OP_SET_POS, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, 7'h00));
    queued_ops.push_back(make_cmd(OP_ENCODER, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 7'h00));
    queued_ops.push_back(make_cmd(OP_TICK, 1'b0, 1'b1, 1'b1, 32'h0, 1'b0, 7'h00));
    queued_ops.push_back(make_cmd(OP_TICK, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 7'h00));
    queued_ops.push_back(make_cmd(OP_READ, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 7'h7F));
    queued_ops.push_back(make_cmd(OP_SET_POS, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 7'h00));
    wait_drained();

    // largest step, inverted polarity, no debounce: captures edges into both tables
    program_setup(8'd255, 1'b0, 8'd0);
    gen_phase(350);
    wait_drained();

    // smallest nonzero step, longest accepted debounce
    send_idle_pct = 58;
    recv_idle_pct = 14;
    program_setup(8'd1, 1'b1, 8'd254);
    gen_phase(560);
    wait_drained();

    // zero step and a limit the saturated counters never exceed
    program_setup(8'd0, 1'b0, 8'd255);
    gen_phase(400);
    wait_drained();

    // mid-range settings, no idling, with a full pause halfway
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_setup(8'($urandom_range(1, 254)), 1'b1, 8'($urandom_range(0, 3)));
    gen_phase(175);
    wait_drained();
    gen_phase(175);
    wait_drained();

    $display("%0d transactions in (%0d table reads), %0d results checked, %0d register writes",
             cmds_taken, reads_taken, reports_seen, reg_writes);
    $display("%0d rising and %0d falling edges captured; tables filled to %0d and %0d slots",
             rises_seen, falls_seen, rise_fill, fall_fill);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
